### hw/rtl/apo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apo_pkg
// Shared types and constants for the ARGB pixel point operations unit.
// ----------------------------------------------------------------------------
package apo_pkg;

  localparam int unsigned ChW   = 8;
  localparam int unsigned NumCh = 3;
  localparam int unsigned PixW  = 32;
  localparam int unsigned ModeW = 4;
  localparam int unsigned OffW  = 9;
  localparam int unsigned GainW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SumW  = 10;
  localparam int unsigned BrtW  = ChW + 2;
  localparam int unsigned ProdW = ChW + 1 + GainW;

  // reciprocal of three, 683 / 2048, exact for sums up to 765
  localparam int unsigned RecipW     = 10;
  localparam int unsigned RecipShift = 11;
  localparam logic [RecipW-1:0] Recip3 = RecipW'(683);

  localparam logic [ChW-1:0] ChMax = 8'hff;
  localparam logic [GainW-1:0] GainReset = 16'h0100;

  typedef enum logic [ModeW-1:0] {
    MODE_GRAYMAX    = 4'd0,
    MODE_GRAYMIN    = 4'd1,
    MODE_GRAYAVG    = 4'd2,
    MODE_INVERT     = 4'd3,
    MODE_NOBLUE     = 4'd4,
    MODE_NOGREEN    = 4'd5,
    MODE_NORED      = 4'd6,
    MODE_BRIGHTNESS = 4'd7,
    MODE_CONTRAST   = 4'd8
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE   = 2'd0,
    CFG_OFFSET = 2'd1,
    CFG_GAIN   = 2'd2
  } cfg_idx_t;

  // channel index: 2 red, 1 green, 0 blue
  typedef logic [NumCh-1:0][ChW-1:0] rgb_t;

  typedef struct packed {
    logic load;
    logic valid;
  } stage_ctl_t;

  typedef struct packed {
    logic [ChW-1:0]                    alpha;
    logic [ModeW-1:0]                  mode;
    rgb_t                              ch;
    logic [ChW-1:0]                    mx;
    logic [ChW-1:0]                    mn;
    logic [SumW-1:0]                   sum;
    logic [NumCh-1:0][BrtW-1:0]        brt;
    logic [NumCh-1:0][ProdW-1:0]       prod;
  } s1_t;

  typedef struct packed {
    logic [ChW-1:0]   alpha;
    logic [ModeW-1:0] mode;
    rgb_t             ch;
    logic [ChW-1:0]   mx;
    logic [ChW-1:0]   mn;
    logic [ChW-1:0]   avg;
    rgb_t             brt;
    rgb_t             con;
  } s2_t;

endpackage
`default_nettype wire

### hw/rtl/apo_s1_arith.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apo_s1_arith
// First stage: channel unpack, max/min, sum, brightness add, contrast multiply.
// ----------------------------------------------------------------------------
module apo_s1_arith (
  input  wire                              clk,
  input  wire                              rst_n,
  input  apo_pkg::stage_ctl_t              ctl,
  input  wire [apo_pkg::PixW-1:0]          pixel,
  input  wire [apo_pkg::ModeW-1:0]         mode,
  input  wire signed [apo_pkg::OffW-1:0]   offset,
  input  wire signed [apo_pkg::GainW-1:0]  gain,
  output logic                             valid_r,
  output apo_pkg::s1_t                     q_r
);

  apo_pkg::s1_t   q_nxt;
  apo_pkg::rgb_t  ch;
  logic [apo_pkg::ChW-1:0] mx_rg;
  logic [apo_pkg::ChW-1:0] mn_rg;

  always_comb begin
    ch    = apo_pkg::rgb_t'(pixel[apo_pkg::NumCh*apo_pkg::ChW-1:0]);
    mx_rg = (ch[2] > ch[1]) ? ch[2] : ch[1];
    mn_rg = (ch[2] < ch[1]) ? ch[2] : ch[1];
    q_nxt.alpha = pixel[apo_pkg::PixW-1 -: apo_pkg::ChW];
    q_nxt.mode  = mode;
    q_nxt.ch    = ch;
    q_nxt.mx    = (mx_rg > ch[0]) ? mx_rg : ch[0];
    q_nxt.mn    = (mn_rg < ch[0]) ? mn_rg : ch[0];
    q_nxt.sum   = apo_pkg::SumW'(ch[2]) + apo_pkg::SumW'(ch[1]) + apo_pkg::SumW'(ch[0]);
    for (int i = 0; i < apo_pkg::NumCh; i++) begin
      q_nxt.brt[i]  = $signed({2'b00, ch[i]}) + $signed({offset[apo_pkg::OffW-1], offset});
      q_nxt.prod[i] = $signed({{apo_pkg::GainW{1'b0}}, 1'b0, ch[i]})
                    * $signed({{(apo_pkg::ChW+1){gain[apo_pkg::GainW-1]}}, gain});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/apo_s2_clamp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apo_s2_clamp
// Second stage: clamp brightness and contrast results, divide the sum by three.
// ----------------------------------------------------------------------------
module apo_s2_clamp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  apo_pkg::stage_ctl_t  ctl,
  input  apo_pkg::s1_t         d,
  output logic                 valid_r,
  output apo_pkg::s2_t         q_r
);

  apo_pkg::s2_t q_nxt;
  logic [apo_pkg::SumW+apo_pkg::RecipW-1:0] avg_prod;

  always_comb begin
    avg_prod    = apo_pkg::SumW'(d.sum) * apo_pkg::Recip3;
    q_nxt.alpha = d.alpha;
    q_nxt.mode  = d.mode;
    q_nxt.ch    = d.ch;
    q_nxt.mx    = d.mx;
    q_nxt.mn    = d.mn;
    q_nxt.avg   = avg_prod[apo_pkg::RecipShift +: apo_pkg::ChW];
    for (int i = 0; i < apo_pkg::NumCh; i++) begin
      if (d.brt[i][apo_pkg::BrtW-1]) begin
        q_nxt.brt[i] = '0;
      end else if (d.brt[i][apo_pkg::ChW]) begin
        q_nxt.brt[i] = apo_pkg::ChMax;
      end else begin
        q_nxt.brt[i] = d.brt[i][apo_pkg::ChW-1:0];
      end
      if (d.prod[i][apo_pkg::ProdW-1]) begin
        q_nxt.con[i] = '0;
      end else if (|d.prod[i][apo_pkg::ProdW-2:2*apo_pkg::ChW]) begin
        q_nxt.con[i] = apo_pkg::ChMax;
      end else begin
        q_nxt.con[i] = d.prod[i][2*apo_pkg::ChW-1:apo_pkg::ChW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/apo_s3_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apo_s3_select
// Output stage: pick the channels for the mode and register the pixel.
// ----------------------------------------------------------------------------
module apo_s3_select (
  input  wire                         clk,
  input  wire                         rst_n,
  input  apo_pkg::stage_ctl_t         ctl,
  input  apo_pkg::s2_t                d,
  output logic                        valid_r,
  output logic [apo_pkg::PixW-1:0]    pixel_r
);

  apo_pkg::rgb_t ch;
  logic [apo_pkg::PixW-1:0] pixel_nxt;

  always_comb begin
    ch = d.ch;
    case (apo_pkg::mode_t'(d.mode))
      apo_pkg::MODE_GRAYMAX:    ch = {apo_pkg::NumCh{d.mx}};
      apo_pkg::MODE_GRAYMIN:    ch = {apo_pkg::NumCh{d.mn}};
      apo_pkg::MODE_GRAYAVG:    ch = {apo_pkg::NumCh{d.avg}};
      apo_pkg::MODE_INVERT:     ch = ~d.ch;
      apo_pkg::MODE_NOBLUE:     ch[0] = '0;
      apo_pkg::MODE_NOGREEN:    ch[1] = '0;
      apo_pkg::MODE_NORED:      ch[2] = '0;
      apo_pkg::MODE_BRIGHTNESS: ch = d.brt;
      apo_pkg::MODE_CONTRAST:   ch = d.con;
      default:                  ch = d.ch;
    endcase
    pixel_nxt = {d.alpha, ch};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pixel_r <= pixel_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/argb_pixel_point_ops_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// argb_pixel_point_ops_unit
// Per-pixel ARGB8888 point operations: gray, invert, channel drop,
// brightness and contrast. Alpha passes through unchanged.
//
// Input channel in_valid / in_stall / in_pixel_in: an item is taken on a
// rising edge with in_valid high and in_stall low. Output channel
// out_valid / out_stall / out_pixel_out works the same way, out_stall
// driven by the receiver.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is
// always high. Index 0 mode, 1 brightness offset, 2 contrast gain (Q8.8);
// index 3 is ignored. Write only while no items are in flight.
// Pipeline: three register stages (arith, clamp, select); an accepted item
// passes through all three before out_valid shows it. Throughput: one item
// per cycle while out_stall is low, when every stage loads each cycle.
// Each stage holds while the stage after it is full and stalled, so empty
// stages keep filling; in_stall rises only when all three stages are full
// and out_stall is high. Nothing is dropped or repeated under stall.
// Reset (rst_n low, synchronous) empties the pipeline and sets mode 0,
// offset 0 and gain 1.0.
// ----------------------------------------------------------------------------
module argb_pixel_point_ops_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire [apo_pkg::PixW-1:0]           in_pixel_in,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [apo_pkg::PixW-1:0]          out_pixel_out,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [apo_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire [apo_pkg::CfgDataW-1:0]       cfg_data
);

  logic [apo_pkg::ModeW-1:0]        mode_r;
  logic signed [apo_pkg::OffW-1:0]  offset_r;
  logic signed [apo_pkg::GainW-1:0] gain_r;

  logic                 v1, v2, v3;
  logic                 en1, en2, en3;
  apo_pkg::s1_t         s1_q;
  apo_pkg::s2_t         s2_q;
  apo_pkg::stage_ctl_t  ctl1, ctl2, ctl3;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= apo_pkg::MODE_GRAYMAX;
      offset_r <= '0;
      gain_r   <= apo_pkg::GainReset;
    end else if (cfg_valid && cfg_ready) begin
      case (apo_pkg::cfg_idx_t'(cfg_index))
        apo_pkg::CFG_MODE:   mode_r   <= cfg_data[apo_pkg::ModeW-1:0];
        apo_pkg::CFG_OFFSET: offset_r <= cfg_data[apo_pkg::OffW-1:0];
        apo_pkg::CFG_GAIN:   gain_r   <= cfg_data[apo_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the next one advances
  always_comb begin
    en3 = !v3 || !out_stall;
    en2 = !v2 || en3;
    en1 = !v1 || en2;
    in_stall    = !en1;
    ctl1.load   = en1;
    ctl1.valid  = in_valid;
    ctl2.load   = en2;
    ctl2.valid  = v1;
    ctl3.load   = en3;
    ctl3.valid  = v2;
  end

  apo_s1_arith u_s1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl1),
    .pixel   (in_pixel_in),
    .mode    (mode_r),
    .offset  (offset_r),
    .gain    (gain_r),
    .valid_r (v1),
    .q_r     (s1_q)
  );

  apo_s2_clamp u_s2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl2),
    .d       (s1_q),
    .valid_r (v2),
    .q_r     (s2_q)
  );

  apo_s3_select u_s3 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl3),
    .d       (s2_q),
    .valid_r (v3),
    .pixel_r (out_pixel_out)
  );

  assign out_valid = v3;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1 && v2 && v3 && out_stall))
    else $error("input stalled while the pipeline has room");

  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (mode_r == apo_pkg::MODE_GRAYMAX || mode_r == apo_pkg::MODE_GRAYMIN
                   || mode_r == apo_pkg::MODE_GRAYAVG))
    |-> (out_pixel_out[23:16] == out_pixel_out[15:8]
         && out_pixel_out[15:8] == out_pixel_out[7:0]))
    else $error("gray mode produced unequal channels");

  a_noblue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && mode_r == apo_pkg::MODE_NOBLUE) |-> (out_pixel_out[7:0] == 8'h00))
    else $error("blue not cleared");

  a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v2 && !v3) |=> v3)
    else $error("output stage failed to load");

endmodule
`default_nettype wire
